// ===== sv/tid_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the touch input debouncer.
// No dependencies; imported by every module of the block.
package tid_pkg;

  localparam int SAMPLE_BITS   = 12;
  localparam int TIME_BITS     = 32;
  localparam int DEBOUNCE_BITS = 16;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ANALOG_MODE      = 2'd0,
    REG_TOUCH_THRESHOLD  = 2'd1,
    REG_DEBOUNCE_TIME    = 2'd2,
    REG_LEVEL_ACTIVE_LOW = 2'd3
  } cfg_reg_t;

  localparam logic                     RST_ANALOG_MODE      = 1'b0;
  localparam logic [SAMPLE_BITS-1:0]   RST_TOUCH_THRESHOLD  = SAMPLE_BITS'(2048);
  localparam logic [DEBOUNCE_BITS-1:0] RST_DEBOUNCE_TIME    = DEBOUNCE_BITS'(50);
  localparam logic                     RST_LEVEL_ACTIVE_LOW = 1'b1;

  typedef struct packed {
    logic                     analog_mode;
    logic [SAMPLE_BITS-1:0]   touch_threshold;
    logic [DEBOUNCE_BITS-1:0] debounce_time;
    logic                     level_active_low;
  } cfg_t;

  typedef struct packed {
    logic                   started;
    logic [SAMPLE_BITS-1:0] previous_raw;
    logic                   stable_touched;
    logic [TIME_BITS-1:0]   touch_start_time;
    logic [TIME_BITS-1:0]   last_change_time;
    logic                   pending_touch;
    logic                   pending_release;
  } state_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_value;
    logic [TIME_BITS-1:0]   time_ms;
    logic                   ack_touch_flag;
    logic                   ack_release_flag;
  } item_t;

  typedef struct packed {
    logic                   is_touched;
    logic                   touch_event;
    logic                   release_event;
    logic [TIME_BITS-1:0]   held_duration;
    logic [SAMPLE_BITS-1:0] latest_value;
  } result_t;

endpackage

// ===== sv/touch_input_debouncer_core.sv =====
`timescale 1ns / 1ps
// Touch input debouncer top level: input register, step logic, result register.
// Depends on tid_pkg, tid_cfg_regs and tid_step.

// Debounces one touch sensor, one timestamped sample per transfer, and gives
// exactly one result per sample. Throughput is one sample per clock while
// out_stall is low: the whole debounce step (threshold or level compare,
// raw-change check, one elapsed-time subtract and compare, duration subtract)
// sits between the input register and the result register, and the debounce
// state updates in the same cycle the result is loaded, so the next sample
// sees it. out_valid rises once the item has moved from the input register
// into the result register. While a result waits on out_stall the input
// register can still take one sample; in_stall rises only when both
// registers are full and the result is stalled.
// The first sample after reset only seeds the state. Configuration writes
// (cfg_write/cfg_index/cfg_data) take effect on the next processed sample
// and should only be issued while no sample is in flight.
module touch_input_debouncer_core (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_write,
  input  logic [tid_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [tid_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  // sample channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [tid_pkg::SAMPLE_BITS-1:0]    sample_value,
  input  logic [tid_pkg::TIME_BITS-1:0]      time_ms,
  input  logic                               ack_touch_flag,
  input  logic                               ack_release_flag,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               is_touched,
  output logic                               touch_event,
  output logic                               release_event,
  output logic [tid_pkg::TIME_BITS-1:0]      held_duration,
  output logic [tid_pkg::SAMPLE_BITS-1:0]    latest_value
);
  import tid_pkg::*;

  cfg_t    cfg;
  state_t  state;
  state_t  state_next;
  item_t   item;
  result_t result;
  result_t res;

  logic in_full;
  logic advance;
  logic in_take;

  tid_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tid_step u_step (
    .cfg        (cfg),
    .state      (state),
    .item       (item),
    .state_next (state_next),
    .result     (result)
  );

  // item moves to the result register when that register is empty or draining
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item.sample_value     <= sample_value;
      item.time_ms          <= time_ms;
      item.ack_touch_flag   <= ack_touch_flag;
      item.ack_release_flag <= ack_release_flag;
    end
  end

  // debounce state, committed as the item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= result;
    end
  end

  assign is_touched    = res.is_touched;
  assign touch_event   = res.touch_event;
  assign release_event = res.release_event;
  assign held_duration = res.held_duration;
  assign latest_value  = res.latest_value;

  // once seeded, the state stays seeded until reset
  a_started_sticks: assert property (@(posedge clk) disable iff (rst)
    state.started |=> state.started)
    else $error("debounce state lost its started mark");

  // released state always carries a cleared touch start time
  a_release_clears_start: assert property (@(posedge clk) disable iff (rst)
    !state.stable_touched |-> state.touch_start_time == '0)
    else $error("touch start time nonzero while released");

  // an advancing item always lands in the result register
  a_advance_loads: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result register not loaded after advance");

  // back-pressure only with a full input register behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_full && out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // released results report zero duration
  a_zero_duration: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !is_touched) |-> held_duration == '0)
    else $error("nonzero duration on a released result");

endmodule

// ===== sv/tid_cfg_regs.sv =====
`timescale 1ns / 1ps
// Configuration register file for the touch input debouncer.
// Depends on tid_pkg.
module tid_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [tid_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [tid_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output tid_pkg::cfg_t                       cfg
);
  import tid_pkg::*;

  cfg_t cfg_next;

  always_comb begin
    cfg_next = cfg;
    if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_ANALOG_MODE:      cfg_next.analog_mode      = cfg_data[0];
        REG_TOUCH_THRESHOLD:  cfg_next.touch_threshold  = cfg_data[SAMPLE_BITS-1:0];
        REG_DEBOUNCE_TIME:    cfg_next.debounce_time    = cfg_data[DEBOUNCE_BITS-1:0];
        REG_LEVEL_ACTIVE_LOW: cfg_next.level_active_low = cfg_data[0];
        default:              cfg_next = cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.analog_mode      <= RST_ANALOG_MODE;
      cfg.touch_threshold  <= RST_TOUCH_THRESHOLD;
      cfg.debounce_time    <= RST_DEBOUNCE_TIME;
      cfg.level_active_low <= RST_LEVEL_ACTIVE_LOW;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

// ===== sv/tid_step.sv =====
`timescale 1ns / 1ps
// Per-sample debounce step: next state and result from one registered item.
// Depends on tid_pkg.
module tid_step (
  input  tid_pkg::cfg_t    cfg,
  input  tid_pkg::state_t  state,
  input  tid_pkg::item_t   item,
  output tid_pkg::state_t  state_next,
  output tid_pkg::result_t result
);
  import tid_pkg::*;

  logic                 touched;
  logic [TIME_BITS-1:0] elapsed;
  logic                 settled;
  state_t               upd;

  always_comb begin
    if (cfg.analog_mode) begin
      touched = item.sample_value > cfg.touch_threshold;
    end else if (cfg.level_active_low) begin
      touched = item.sample_value == '0;
    end else begin
      touched = item.sample_value == SAMPLE_BITS'(1);
    end
  end

  assign elapsed = item.time_ms - state.last_change_time;
  assign settled = elapsed >= TIME_BITS'(cfg.debounce_time);

  always_comb begin
    upd = state;
    if (!state.started) begin
      upd.started          = 1'b1;
      upd.previous_raw     = item.sample_value;
      upd.stable_touched   = touched;
      upd.touch_start_time = touched ? item.time_ms : '0;
      upd.last_change_time = item.time_ms;
      upd.pending_touch    = 1'b0;
      upd.pending_release  = 1'b0;
    end else if (item.sample_value != state.previous_raw) begin
      upd.last_change_time = item.time_ms;
      upd.previous_raw     = item.sample_value;
      // rising edge of the raw reading takes effect immediately
      if (touched && !state.stable_touched) begin
        upd.pending_touch    = 1'b1;
        upd.stable_touched   = 1'b1;
        upd.touch_start_time = item.time_ms;
      end
    end else if (settled && (touched != state.stable_touched)) begin
      if (touched) begin
        upd.pending_touch    = 1'b1;
        upd.touch_start_time = item.time_ms;
      end else begin
        upd.pending_release  = 1'b1;
        upd.touch_start_time = '0;
      end
      upd.stable_touched = touched;
    end
  end

  always_comb begin
    result.is_touched    = upd.stable_touched;
    result.touch_event   = upd.pending_touch;
    result.release_event = upd.pending_release;
    result.held_duration = upd.stable_touched ? (item.time_ms - upd.touch_start_time) : '0;
    result.latest_value  = item.sample_value;

    state_next                 = upd;
    state_next.pending_touch   = upd.pending_touch & ~item.ack_touch_flag;
    state_next.pending_release = upd.pending_release & ~item.ack_release_flag;
  end

endmodule
